/* rtl/core/bsl_pkg.sv */
package bsl_pkg;

	localparam int unsigned DEPTH   = 256;
	localparam int unsigned ADDR_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
	localparam int unsigned KIND_W  = 4;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned IDX_W   = 9;

	localparam logic [IDX_W-1:0] MISS_INDEX = '1;
	localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);

	typedef enum logic [KIND_W-1:0] {
		K_PUSH_BACK  = 4'd0,
		K_POP_BACK   = 4'd1,
		K_PUSH_FRONT = 4'd2,
		K_POP_FRONT  = 4'd3,
		K_INSERT     = 4'd4,
		K_ERASE      = 4'd5,
		K_OVERWRITE  = 4'd6,
		K_FIND       = 4'd7,
		K_READ       = 4'd8
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		S_OK     = 2'd0,
		S_EMPTY  = 2'd1,
		S_FULL   = 2'd2,
		S_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHUP,
		ST_SHDN,
		ST_FIND,
		ST_READ,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

/* rtl/core/bsl_if.sv */
interface bsl_req_if;
	logic                          valid;
	logic                          ready;
	logic [bsl_pkg::KIND_W-1:0]    kind;
	logic [bsl_pkg::POS_W-1:0]     position;
	logic signed [bsl_pkg::DATA_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface bsl_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [bsl_pkg::STAT_W-1:0]        status;
	logic signed [bsl_pkg::IDX_W-1:0]  found_index;
	logic signed [bsl_pkg::DATA_W-1:0] read_value;
	logic [bsl_pkg::CNT_W-1:0]         count;

	modport source (output valid, status, found_index, read_value, count, input ready);
	modport sink   (input valid, status, found_index, read_value, count, output ready);
endinterface

/* rtl/core/bsl_ram.sv */
module bsl_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 256,
	localparam int unsigned AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/bounded_sequential_list_unit.sv */
// Channel | Dir | Payload                                   | Handshake
// req     | in  | kind, position, value                     | valid/ready
// rsp     | out | status, found_index, read_value, count    | valid/ready
//
// One item is in work at a time. Push back, pop back, overwrite and errors go
// from idle straight to the emit state; read passes through the read state first.
// Push front, insert, pop front and erase move one entry per cycle through the
// single write port of the store, then pass the drain state before emit. Find
// reads one entry per cycle. Reset clears the count and control; the store holds
// no reset value. A waiting result does not block acceptance; a stalled result
// holds the next item in the emit state until the output register frees.
module bounded_sequential_list_unit (
	input logic    clk,
	input logic    arst_n,
	bsl_req_if.sink   req,
	bsl_rsp_if.source rsp
);
	import bsl_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    ptr_q, ptr_d;
	logic                s1_vld_s1, s1_vld_d;
	logic [ADDR_W-1:0]   s1_addr_s1, s1_addr_d;
	logic                rsp_vld_q, rsp_vld_d;

	kind_t               kind_q, kind_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [DATA_W-1:0]   val_q, val_d;
	status_t             status_q, status_d;
	logic [IDX_W-1:0]    found_q, found_d;
	logic [DATA_W-1:0]   rd_q, rd_d;

	logic [STAT_W-1:0]   rsp_status_q;
	logic [IDX_W-1:0]    rsp_found_q;
	logic [DATA_W-1:0]   rsp_rd_q;
	logic [CNT_W-1:0]    rsp_count_q;
	logic                rsp_load;

	logic                we;
	logic [ADDR_W-1:0]   waddr, raddr;
	logic [DATA_W-1:0]   wdata, rdata;

	logic                full, empty, up_op;
	logic [CNT_W-1:0]    pos_ext, epos_ext;
	kind_t               req_kind;

	bsl_ram #(.Width(DATA_W), .Depth(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign req_kind = kind_t'(req.kind);
	assign pos_ext  = CNT_W'(req.position);
	assign epos_ext = (req_kind == K_POP_FRONT) ? '0 : pos_ext;
	assign up_op    = (kind_q == K_PUSH_FRONT) || (kind_q == K_INSERT);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		s1_vld_d  = 1'b0;
		s1_addr_d = s1_addr_s1;
		kind_d    = kind_q;
		pos_d     = pos_q;
		val_d     = val_q;
		status_d  = status_q;
		found_d   = found_q;
		rd_d      = rd_q;
		we        = 1'b0;
		waddr     = s1_addr_s1;
		wdata     = rdata;
		raddr     = ptr_q[ADDR_W-1:0];
		req.ready = 1'b0;
		rsp_load  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				raddr     = req.position;
				if (req.valid) begin
					kind_d   = req_kind;
					pos_d    = req.position;
					val_d    = req.value;
					status_d = S_OK;
					found_d  = MISS_INDEX;
					rd_d     = '0;
					state_d  = ST_EMIT;
					case (req_kind)
						K_PUSH_BACK: begin
							if (full) begin
								status_d = S_FULL;
							end else begin
								we      = 1'b1;
								waddr   = count_q[ADDR_W-1:0];
								wdata   = req.value;
								count_d = count_q + CNT_W'(1);
							end
						end
						K_POP_BACK: begin
							if (empty) begin
								status_d = S_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
							end
						end
						K_PUSH_FRONT, K_INSERT: begin
							if (req_kind == K_PUSH_FRONT) begin
								pos_d = '0;
							end
							if (full) begin
								status_d = S_FULL;
							end else if (req_kind == K_INSERT &&
									!(pos_ext < count_q || (pos_ext == '0 && empty))) begin
								status_d = S_BADPOS;
							end else if (empty) begin
								state_d = ST_DRAIN;
							end else begin
								ptr_d   = count_q - CNT_W'(1);
								state_d = ST_SHUP;
							end
						end
						K_POP_FRONT, K_ERASE: begin
							if (req_kind == K_POP_FRONT && empty) begin
								status_d = S_EMPTY;
							end else if (epos_ext >= count_q) begin
								status_d = S_BADPOS;
							end else if (epos_ext + CNT_W'(1) == count_q) begin
								state_d = ST_DRAIN;
							end else begin
								ptr_d   = epos_ext + CNT_W'(1);
								state_d = ST_SHDN;
							end
						end
						K_OVERWRITE: begin
							if (pos_ext >= count_q) begin
								status_d = S_BADPOS;
							end else begin
								we    = 1'b1;
								waddr = req.position;
								wdata = req.value;
							end
						end
						K_FIND: begin
							ptr_d   = '0;
							state_d = ST_FIND;
						end
						K_READ: begin
							if (pos_ext >= count_q) begin
								status_d = S_BADPOS;
							end else begin
								state_d = ST_READ;
							end
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_SHUP: begin
				we        = s1_vld_s1;
				s1_vld_d  = 1'b1;
				s1_addr_d = ptr_q[ADDR_W-1:0] + ADDR_W'(1);
				if (ptr_q[ADDR_W-1:0] == pos_q) begin
					state_d = ST_DRAIN;
				end else begin
					ptr_d = ptr_q - CNT_W'(1);
				end
			end
			ST_SHDN: begin
				we        = s1_vld_s1;
				s1_vld_d  = 1'b1;
				s1_addr_d = ptr_q[ADDR_W-1:0] - ADDR_W'(1);
				if (ptr_q == count_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end
			ST_DRAIN: begin
				if (s1_vld_s1) begin
					we = 1'b1;
				end else if (up_op) begin
					we      = 1'b1;
					waddr   = pos_q;
					wdata   = val_q;
					count_d = count_q + CNT_W'(1);
					state_d = ST_EMIT;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_EMIT;
				end
			end
			ST_FIND: begin
				if (s1_vld_s1 && rdata == val_q) begin
					found_d = IDX_W'(s1_addr_s1);
					state_d = ST_EMIT;
				end else if (ptr_q < count_q) begin
					s1_vld_d  = 1'b1;
					s1_addr_d = ptr_q[ADDR_W-1:0];
					ptr_d     = ptr_q + CNT_W'(1);
				end else if (!s1_vld_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_READ: begin
				rd_d    = rdata;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!rsp_vld_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (rsp_load) begin
			rsp_vld_d = 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_d = 1'b0;
		end else begin
			rsp_vld_d = rsp_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			s1_vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ptr_q     <= ptr_d;
			s1_vld_s1 <= s1_vld_d;
			rsp_vld_q <= rsp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		s1_addr_s1 <= s1_addr_d;
		kind_q     <= kind_d;
		pos_q      <= pos_d;
		val_q      <= val_d;
		status_q   <= status_d;
		found_q    <= found_d;
		rd_q       <= rd_d;
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_rd_q     <= rd_q;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_index = rsp_found_q;
	assign rsp.read_value  = rsp_rd_q;
	assign rsp.count       = rsp_count_q;

endmodule

/* rtl/core/bsl_checker.sv */
module bsl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bsl_pkg::STAT_W-1:0]   rsp_status,
	input logic [bsl_pkg::IDX_W-1:0]    rsp_found,
	input logic [bsl_pkg::CNT_W-1:0]    rsp_count
);
	import bsl_pkg::*;

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// The count never exceeds the store size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= DEPTH_CNT)
		else $error("count beyond store size");

	// A refused push is reported only on a full list.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == S_FULL |-> rsp_count == DEPTH_CNT)
		else $error("full status with room left");

	// A refused pop is reported only on an empty list.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == S_EMPTY |-> rsp_count == '0)
		else $error("empty status on a non-empty list");

	// A hit lies inside the list and comes with an ok status.
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found != MISS_INDEX |-> rsp_found < rsp_count && rsp_status == S_OK)
		else $error("found index outside the list");

endmodule

bind bounded_sequential_list_unit bsl_checker u_bsl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_found  (rsp.found_index),
	.rsp_count  (rsp.count)
);

/* bench/bsl_result_checker.sv */
module bsl_result_checker
	import bsl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bsl_req_if   req,
	bsl_rsp_if   rsp,
	output int   mismatches,
	output int   pending
);

	typedef struct {
		status_t                  status;
		logic signed [IDX_W-1:0]  found_index;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
	} list_result_t;

	logic signed [DATA_W-1:0] shadow_store [DEPTH];
	logic [CNT_W-1:0]         shadow_count;
	list_result_t             expected_results [$];
	int                       results_seen;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string field, input logic signed [63:0] got,
			input logic signed [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
				results_seen, field, got, want));
		end
	endtask

	function automatic void open_gap_at(input int pos);
		int i;
		for (i = shadow_count; i > pos; i--) begin
			shadow_store[i] = shadow_store[i - 1];
		end
	endfunction

	function automatic void close_gap_at(input int pos);
		int i;
		for (i = pos; i + 1 < shadow_count; i++) begin
			shadow_store[i] = shadow_store[i + 1];
		end
	endfunction

	function automatic list_result_t apply_list_request(input logic [KIND_W-1:0] kind,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_result_t res;
		int i;
		res.status      = S_OK;
		res.found_index = MISS_INDEX;
		res.read_value  = '0;
		case (kind)
			K_PUSH_BACK: begin
				if (shadow_count == DEPTH_CNT) begin
					res.status = S_FULL;
				end else begin
					shadow_store[shadow_count] = val;
					shadow_count++;
				end
			end
			K_PUSH_FRONT: begin
				if (shadow_count == DEPTH_CNT) begin
					res.status = S_FULL;
				end else begin
					open_gap_at(0);
					shadow_store[0] = val;
					shadow_count++;
				end
			end
			K_POP_BACK: begin
				if (shadow_count == 0) begin
					res.status = S_EMPTY;
				end else begin
					shadow_count--;
				end
			end
			K_POP_FRONT: begin
				if (shadow_count == 0) begin
					res.status = S_EMPTY;
				end else begin
					close_gap_at(0);
					shadow_count--;
				end
			end
			K_INSERT: begin
				// The full check takes precedence over the position check.
				if (shadow_count == DEPTH_CNT) begin
					res.status = S_FULL;
				end else if (!(pos < shadow_count || (pos == 0 && shadow_count == 0))) begin
					res.status = S_BADPOS;
				end else begin
					open_gap_at(pos);
					shadow_store[pos] = val;
					shadow_count++;
				end
			end
			K_ERASE: begin
				if (pos >= shadow_count) begin
					res.status = S_BADPOS;
				end else begin
					close_gap_at(pos);
					shadow_count--;
				end
			end
			K_OVERWRITE: begin
				if (pos >= shadow_count) begin
					res.status = S_BADPOS;
				end else begin
					shadow_store[pos] = val;
				end
			end
			K_FIND: begin
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_store[i] == val) begin
						res.found_index = IDX_W'(i);
						break;
					end
				end
			end
			K_READ: begin
				if (pos >= shadow_count) begin
					res.status = S_BADPOS;
				end else begin
					res.read_value = shadow_store[pos];
				end
			end
			default: begin
			end
		endcase
		res.count = shadow_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		list_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			shadow_count = '0;
			mismatches   = 0;
			results_seen = 0;
			pending     <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request outstanding",
						results_seen));
				end else begin
					want = expected_results.pop_front();
					compare_field("status", rsp.status, want.status);
					compare_field("found_index", rsp.found_index, want.found_index);
					compare_field("read_value", rsp.read_value, want.read_value);
					compare_field("count", rsp.count, want.count);
				end
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_list_request(req.kind, req.position, req.value));
			end
			pending <= expected_results.size();
		end
	end

endmodule

/* bench/tb.sv */
module tb;
	import bsl_pkg::*;

	localparam int TOTAL_ITEMS    = 1800;
	localparam int QUIET_FROM     = 1600;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

	logic clk;
	logic arst_n;

	bsl_req_if req_ch ();
	bsl_rsp_if rsp_ch ();

	int mismatches;
	int pending;
	int sent          = 0;
	int list_len      = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	int idle_cycles   = 0;
	bit req_idle_on   = 1'b1;
	bit rsp_idle_on   = 1'b1;

	bounded_sequential_list_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bsl_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int len_after(input kind_t k, input logic [POS_W-1:0] p, input int n);
		case (k)
			K_PUSH_BACK, K_PUSH_FRONT: return (n < DEPTH) ? n + 1 : n;
			K_INSERT: return (n < DEPTH && (p < n || (p == 0 && n == 0))) ? n + 1 : n;
			K_POP_BACK, K_POP_FRONT: return (n > 0) ? n - 1 : n;
			K_ERASE: return (p < n) ? n - 1 : n;
			default: return n;
		endcase
	endfunction

	// Small values repeat often so that searches hit as well as miss.
	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return DATA_W'($urandom_range(0, 7));
		end else if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return -32'sd1;
				default: return '0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return POS_W'($urandom_range(0, 255));
		end else if (r == 1) begin
			return (list_len > 255) ? POS_W'(255) : POS_W'(list_len);
		end
		return (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
	endfunction

	function automatic kind_t pick_kind(input mix_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_GROW: begin
				if (r < 25) return K_PUSH_BACK;
				else if (r < 40) return K_PUSH_FRONT;
				else if (r < 60) return K_INSERT;
				else if (r < 68) return K_OVERWRITE;
				else if (r < 80) return K_FIND;
				else if (r < 92) return K_READ;
				else if (r < 96) return K_POP_BACK;
				else if (r < 98) return K_POP_FRONT;
				return K_ERASE;
			end
			MODE_SHRINK: begin
				if (r < 25) return K_POP_BACK;
				else if (r < 40) return K_POP_FRONT;
				else if (r < 60) return K_ERASE;
				else if (r < 65) return K_OVERWRITE;
				else if (r < 75) return K_FIND;
				else if (r < 85) return K_READ;
				else if (r < 95) return K_PUSH_BACK;
				return K_INSERT;
			end
			default: return kind_t'(r % 9);
		endcase
	endfunction

	task automatic issue_request(input kind_t k, input logic [POS_W-1:0] p,
			input logic signed [DATA_W-1:0] v);
		if (sent >= QUIET_FROM) begin
			rsp_idle_on = 1'b0;
		end
		if (req_idle_on && sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= k;
		req_ch.position <= p;
		req_ch.value    <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
		list_len = len_after(k, p, list_len);
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Fill the list to capacity, hit the full and top-index cases, then empty most of it.
	task automatic run_full_list_episode();
		while (list_len < DEPTH) begin
			issue_request(($urandom_range(0, 9) == 0) ? K_PUSH_FRONT : K_PUSH_BACK, '0,
				pick_value());
		end
		issue_request(K_PUSH_BACK, '0, pick_value());
		issue_request(K_PUSH_FRONT, '0, pick_value());
		issue_request(K_INSERT, '0, pick_value());
		issue_request(K_INSERT, POS_W'(255), pick_value());
		issue_request(K_READ, POS_W'(255), '0);
		issue_request(K_OVERWRITE, POS_W'(255), pick_value());
		issue_request(K_FIND, '0, pick_value());
		issue_request(K_ERASE, POS_W'(255), '0);
		issue_request(K_INSERT, POS_W'(128), pick_value());
		issue_request(K_INSERT, POS_W'(64), pick_value());
		repeat (10) issue_request(kind_t'($urandom_range(0, 8)), pick_position(), pick_value());
		while (list_len > 16) begin
			issue_request(($urandom_range(0, 7) == 0) ? K_ERASE : K_POP_BACK, pick_position(),
				pick_value());
		end
	endtask

	initial begin : rsp_stall_gen
		int n;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				n = LONG_HOLD;
			end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
			end else begin
				n = 0;
			end
			if (n == 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		mix_mode_t mode;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= K_PUSH_BACK;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_request(K_POP_BACK, '0, '0);
		issue_request(K_POP_FRONT, '0, '0);
		issue_request(K_ERASE, '0, '0);
		issue_request(K_OVERWRITE, '0, 32'sd9);
		issue_request(K_READ, '0, '0);
		issue_request(K_FIND, '0, '0);
		issue_request(K_INSERT, POS_W'(1), 32'sd3);
		issue_request(K_INSERT, '0, 32'sh7fffffff);
		issue_request(K_PUSH_BACK, '0, 32'sh80000000);
		issue_request(K_PUSH_FRONT, '0, -32'sd1);
		issue_request(K_INSERT, POS_W'(1), '0);
		issue_request(K_INSERT, POS_W'(4), 32'sd7);
		for (int i = 0; i < 4; i++) begin
			issue_request(K_READ, POS_W'(i), '0);
		end
		issue_request(K_FIND, '0, 32'sh80000000);
		issue_request(K_FIND, '0, 32'sd12345);
		issue_request(K_OVERWRITE, POS_W'(2), 32'sd5);
		issue_request(K_ERASE, POS_W'(1), '0);
		issue_request(K_ERASE, POS_W'(3), '0);
		issue_request(K_READ, POS_W'(255), '0);
		issue_request(K_POP_FRONT, '0, '0);
		issue_request(K_POP_BACK, '0, '0);
		issue_request(K_FIND, '0, 32'sd5);
		drain_responses();

		phase = 0;
		while (sent < TOTAL_ITEMS) begin
			req_idle_on = ($urandom_range(0, 3) != 0);
			rsp_idle_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			if (phase == 5 || phase == 20) begin
				hold_requests++;
			end
			if (phase == 2 || phase == 14) begin
				run_full_list_episode();
			end else begin
				if (list_len < 32) begin
					mode = MODE_GROW;
				end else if (list_len > 96) begin
					mode = MODE_SHRINK;
				end else begin
					mode = mix_mode_t'($urandom_range(0, 2));
				end
				n = $urandom_range(20, 60);
				repeat (n) begin
					issue_request(pick_kind(mode), pick_position(), pick_value());
				end
			end
			if (phase % 6 == 3) begin
				drain_responses();
			end
			phase++;
		end

		drain_responses();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/bsl_pkg.sv
rtl/core/bsl_if.sv
rtl/core/bsl_ram.sv
rtl/core/bounded_sequential_list_unit.sv
rtl/core/bsl_checker.sv
bench/bsl_result_checker.sv
bench/tb.sv
